// ----- rtl/core/flacp_pkg.sv -----
// Package for the FLAC stream header parser: item types, result job type,
// status codes and fixed constants. No dependencies.
package flacp_pkg;

  localparam int DIV_W   = 36;  // divider operand width (total samples, seconds)
  localparam int Q_DEPTH = 2;   // result jobs between front and back

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MARK = 2'd1;
  localparam logic [1:0] ST_ZERO_DUR = 2'd2;

  // "fLaC"
  localparam logic [7:0] MARK_0 = 8'h66;
  localparam logic [7:0] MARK_1 = 8'h4C;
  localparam logic [7:0] MARK_2 = 8'h61;
  localparam logic [7:0] MARK_3 = 8'h43;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] min_block;
    logic [15:0] max_block;
    logic [23:0] min_frame;
    logic [23:0] max_frame;
    logic [19:0] sample_rate;
    logic [3:0]  channels;
    logic [5:0]  bits_per_sample;
    logic [35:0] total_samples;
    logic [35:0] total_seconds;
    logic [31:0] data_start;
    logic [34:0] bitrate;
  } out_item_t;

  // What the front hands to the back once parsing of a file ends
  typedef struct packed {
    logic        bad_mark;
    logic [15:0] min_block;
    logic [15:0] max_block;
    logic [23:0] min_frame;
    logic [23:0] max_frame;
    logic [19:0] sample_rate;
    logic [3:0]  channels;
    logic [5:0]  bits_per_sample;
    logic [35:0] total_samples;
    logic [31:0] data_start;
  } job_t;

endpackage

// ----- rtl/core/flacp_front.sv -----
// Byte-level parser: fLaC mark, metadata block headers, STREAMINFO capture.
// Emits one job per file into the queue. Depends on flacp_pkg.
module flacp_front import flacp_pkg::*; #(
  parameter int INFO_BYTES = 18
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_job
);

  localparam int IDX_W = $clog2(INFO_BYTES);

  typedef enum logic [3:0] {
    PH_MAGIC  = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_c;
  logic [31:0] off_r, off_nxt, off_c;
  logic [23:0] fc_r, fc_nxt, fc_c, fc_inc;
  logic [23:0] bl_r, bl_nxt, bl_c;
  logic        last_r, last_nxt, last_c;
  logic        isinfo_r, isinfo_nxt, isinfo_c;
  logic [7:0]  info_r   [INFO_BYTES];
  logic [7:0]  info_nxt [INFO_BYTES];
  logic [7:0]  info_c   [INFO_BYTES];

  logic       accept, restart, blk_done, meta_end, fire, bad;
  logic [7:0] b, mark;

  assign accept = in_valid && !in_stall;
  assign restart = accept && in_data.first_byte;
  assign b = in_data.data_byte;

  always_comb begin
    // state as seen after an optional restart
    phase_c  = restart ? PH_MAGIC : phase_r;
    off_c    = restart ? '0 : off_r;
    fc_c     = restart ? '0 : fc_r;
    bl_c     = restart ? '0 : bl_r;
    last_c   = restart ? 1'b0 : last_r;
    isinfo_c = restart ? 1'b0 : isinfo_r;
    for (int i = 0; i < INFO_BYTES; i++) begin
      info_c[i] = restart ? 8'h00 : info_r[i];
    end

    phase_nxt  = phase_c;
    off_nxt    = off_c;
    fc_nxt     = fc_c;
    bl_nxt     = bl_c;
    last_nxt   = last_c;
    isinfo_nxt = isinfo_c;
    info_nxt   = info_c;
    fc_inc     = fc_c + 24'd1;
    blk_done   = 1'b0;
    meta_end   = 1'b0;
    fire       = 1'b0;
    bad        = 1'b0;

    unique case (fc_c[1:0])
      2'd0:    mark = MARK_0;
      2'd1:    mark = MARK_1;
      2'd2:    mark = MARK_2;
      default: mark = MARK_3;
    endcase

    if (accept && phase_c != PH_DONE) begin
      off_nxt = off_c + 32'd1;
      unique case (phase_c)
        PH_MAGIC: begin
          if (b != mark) begin
            fire      = 1'b1;
            bad       = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            fc_nxt = fc_inc;
            if (fc_inc >= 24'd4) begin
              phase_nxt = PH_HEADER;
              fc_nxt    = '0;
            end
          end
        end
        PH_HEADER: begin
          if (fc_c == '0) begin
            last_nxt   = b[7];
            isinfo_nxt = (b[6:0] == 7'd0);
            bl_nxt     = '0;
          end else begin
            bl_nxt = {bl_c[15:0], b};
          end
          fc_nxt = fc_inc;
          if (fc_inc >= 24'd4) begin
            fc_nxt = '0;
            if (bl_nxt == '0) blk_done = 1'b1;
            else phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (isinfo_c && fc_c < 24'(INFO_BYTES)) begin
            info_nxt[fc_c[IDX_W-1:0]] = b;
          end
          fc_nxt = fc_inc;
          if (fc_inc >= bl_c) blk_done = 1'b1;
        end
        default: ;
      endcase

      if (blk_done) begin
        fc_nxt = '0;
        if (last_nxt) meta_end = 1'b1;
        else phase_nxt = PH_HEADER;
      end

      if (!fire && (meta_end || in_data.last_byte)) begin
        fire      = 1'b1;
        bad       = (phase_nxt == PH_MAGIC);
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      off_r    <= '0;
      fc_r     <= '0;
      bl_r     <= '0;
      last_r   <= 1'b0;
      isinfo_r <= 1'b0;
      for (int i = 0; i < INFO_BYTES; i++) info_r[i] <= 8'h00;
    end else begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      fc_r     <= fc_nxt;
      bl_r     <= bl_nxt;
      last_r   <= last_nxt;
      isinfo_r <= isinfo_nxt;
      info_r   <= info_nxt;
    end
  end

  // STREAMINFO decode, including a byte captured on this same edge
  assign push = fire;
  always_comb begin
    push_job.bad_mark        = bad;
    push_job.min_block       = {info_nxt[0], info_nxt[1]};
    push_job.max_block       = {info_nxt[2], info_nxt[3]};
    push_job.min_frame       = {info_nxt[4], info_nxt[5], info_nxt[6]};
    push_job.max_frame       = {info_nxt[7], info_nxt[8], info_nxt[9]};
    push_job.sample_rate     = {info_nxt[10], info_nxt[11], info_nxt[12][7:4]};
    push_job.channels        = {1'b0, info_nxt[12][3:1]} + 4'd1;
    push_job.bits_per_sample = {1'b0, info_nxt[12][0], info_nxt[13][7:4]} + 6'd1;
    push_job.total_samples   = {info_nxt[13][3:0], info_nxt[14], info_nxt[15],
                                info_nxt[16], info_nxt[17]};
    push_job.data_start      = off_nxt;
  end

endmodule

// ----- rtl/core/flacp_queue.sv -----
// Small job FIFO between parser front and arithmetic back.
// Depends on flacp_pkg.
module flacp_queue import flacp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_t            mem [Q_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(Q_DEPTH));
  assign head  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + (PW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_job;
  end

endmodule

// ----- rtl/core/flacp_div.sv -----
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per divide.
// Depends on flacp_pkg.
module flacp_div import flacp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W:0]   rem_r, rem_nxt, rem_sh;
  logic [DIV_W-1:0] quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic             ge;

  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/flacp_back.sv -----
// Result builder: takes a job, runs seconds and bitrate divisions on the
// shared divider, holds the result in the output register. Depends on flacp_pkg.
module flacp_back import flacp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] file_size,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV1 = 4'b0010,
    S_DIV2 = 4'b0100,
    S_OUT  = 4'b1000
  } bstate_t;

  bstate_t          st_r, st_nxt;
  out_item_t        res_r, res_nxt;
  logic [31:0]      audio_r, audio_nxt;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q;

  flacp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    st_nxt    = st_r;
    res_nxt   = res_r;
    audio_nxt = audio_r;
    pop       = 1'b0;
    div_start = 1'b0;
    div_a     = head.total_samples;
    div_b     = {{(DIV_W-20){1'b0}}, head.sample_rate};
    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          audio_nxt = (file_size > head.data_start) ? file_size - head.data_start : '0;
          res_nxt.status          = ST_OK;
          res_nxt.min_block       = head.min_block;
          res_nxt.max_block       = head.max_block;
          res_nxt.min_frame       = head.min_frame;
          res_nxt.max_frame       = head.max_frame;
          res_nxt.sample_rate     = head.sample_rate;
          res_nxt.channels        = head.channels;
          res_nxt.bits_per_sample = head.bits_per_sample;
          res_nxt.total_samples   = head.total_samples;
          res_nxt.total_seconds   = '0;
          res_nxt.data_start      = head.data_start;
          res_nxt.bitrate         = '0;
          priority if (head.bad_mark) begin
            res_nxt        = '0;
            res_nxt.status = ST_BAD_MARK;
            st_nxt         = S_OUT;
          end else if (head.sample_rate == '0) begin
            res_nxt.status = ST_ZERO_DUR;
            st_nxt         = S_OUT;
          end else begin
            div_start = 1'b1;
            st_nxt    = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        // audio bytes * 8 over the seconds just found
        div_a = {1'b0, audio_r, 3'b000};
        div_b = div_q;
        if (div_done) begin
          res_nxt.total_seconds = div_q;
          if (div_q == '0) begin
            res_nxt.status = ST_ZERO_DUR;
            st_nxt         = S_OUT;
          end else begin
            div_start = 1'b1;
            st_nxt    = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          res_nxt.bitrate = div_q[34:0];
          st_nxt          = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    audio_r <= audio_nxt;
  end

  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;

endmodule

// ----- rtl/core/flac_stream_header_parser_top.sv -----
// Top level of the FLAC stream header parser: file size register, parser
// front, job queue and result back end. Depends on flacp_pkg and the flacp_ modules.
//
// The front takes one file byte per cycle and raises in_stall only while
// both job queue entries are taken. The end of a file (end of metadata,
// last_byte, or a bad fLaC mark) queues one job; the back end turns it
// into a result after two passes of its one-bit-per-cycle restoring
// divider (seconds, then bitrate) and holds it in the output register
// until taken. Bad-mark and zero-rate results skip the divider and go
// straight to the output register; a zero seconds count stops after the
// first pass. file_size is written through cfg_ (always ready); the user
// must write it only while no file is in flight (the block does not check).
module flac_stream_header_parser_top import flacp_pkg::*; #(
  parameter int INFO_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] file_size_r;
  logic        push, pop, q_empty, q_full;
  job_t        push_job, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) file_size_r <= '0;
    else if (cfg_valid && cfg_ready) file_size_r <= cfg_data;
  end

  assign in_stall = q_full;

  flacp_front #(.INFO_BYTES(INFO_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job)
  );

  flacp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  flacp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .file_size (file_size_r),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/flac_stream_header_parser_top_tb.sv -----
// Testbench for flac_stream_header_parser_top: byte stream driver, result monitor and
// a cycle-free parser predictor checked field by field. Depends on flacp_pkg and the RTL.
// Runs directed files, then random files under varying idle rates and backpressure.
module flac_stream_header_parser_top_tb;
  import flacp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INFO_BYTES   = 18;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 600;

  typedef enum logic [1:0] {SCAN_MARK, SCAN_HDR, SCAN_BODY, SCAN_DONE} scan_phase_t;
  typedef enum int {MODE_DIRECTED, MODE_RANDOM, MODE_BURST} stim_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  flac_stream_header_parser_top #(.INFO_BYTES(INFO_BYTES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predictor state
  scan_phase_t ph;
  logic [31:0] offs;
  logic [23:0] fcnt;
  logic [23:0] blk_len;
  logic        last_blk;
  logic        info_blk;
  logic [7:0]  info_buf [INFO_BYTES];
  logic [31:0] file_sz;

  logic [7:0]  mark_seq [4] = '{MARK_0, MARK_1, MARK_2, MARK_3};

  in_item_t    byte_q [$];
  out_item_t   hdr_expect_q [$];

  bit in_fire = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit long_hold_on = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int err_cnt = 0;
  int live_bytes = 0;
  int result_cnt = 0;
  int bad_mark_cnt = 0;
  int zero_dur_cnt = 0;
  int in_held_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_parse();
    ph = SCAN_MARK;
    offs = '0;
    fcnt = '0;
    blk_len = '0;
    last_blk = 1'b0;
    info_blk = 1'b0;
    for (int i = 0; i < INFO_BYTES; i++) info_buf[i] = '0;
  endfunction

  // One accepted byte through the parser; at most one header summary comes out.
  function automatic void parse_byte(input in_item_t it, output bit has_res,
                                     output out_item_t res);
    logic [7:0]  b;
    logic [63:0] rate, samples, secs, audio, rbits;
    bit          blk_done, meta_end;
    has_res = 1'b0;
    res = '0;
    b = it.data_byte;
    blk_done = 1'b0;
    meta_end = 1'b0;
    if (it.first_byte) clear_parse();
    if (ph == SCAN_DONE) return;
    live_bytes++;
    offs = offs + 32'd1;
    case (ph)
      SCAN_MARK: begin
        if (b != mark_seq[fcnt[1:0]]) begin
          res.status = ST_BAD_MARK;
          has_res = 1'b1;
          ph = SCAN_DONE;
          return;
        end
        fcnt = fcnt + 24'd1;
        if (fcnt >= 24'd4) begin
          ph = SCAN_HDR;
          fcnt = '0;
        end
      end
      SCAN_HDR: begin
        if (fcnt == 24'd0) begin
          last_blk = b[7];
          info_blk = (b[6:0] == 7'd0);
          blk_len = '0;
        end else begin
          blk_len = {blk_len[15:0], b};
        end
        fcnt = fcnt + 24'd1;
        if (fcnt >= 24'd4) begin
          fcnt = '0;
          if (blk_len == 24'd0) blk_done = 1'b1;
          else ph = SCAN_BODY;
        end
      end
      default: begin
        if (info_blk && fcnt < INFO_BYTES) info_buf[fcnt[4:0]] = b;
        fcnt = fcnt + 24'd1;
        if (fcnt >= blk_len) blk_done = 1'b1;
      end
    endcase
    if (blk_done) begin
      fcnt = '0;
      if (last_blk) meta_end = 1'b1;
      else ph = SCAN_HDR;
    end
    if (meta_end || it.last_byte) begin
      has_res = 1'b1;
      if (ph == SCAN_MARK) begin
        res.status = ST_BAD_MARK;
      end else begin
        rate = {44'd0, info_buf[10], info_buf[11], info_buf[12][7:4]};
        samples = {28'd0, info_buf[13][3:0], info_buf[14], info_buf[15],
                   info_buf[16], info_buf[17]};
        secs = (rate != 64'd0) ? samples / rate : 64'd0;
        audio = (file_sz > offs) ? {32'd0, file_sz - offs} : 64'd0;
        rbits = (secs != 64'd0) ? (audio * 64'd8) / secs : 64'd0;
        res.status          = (secs != 64'd0) ? ST_OK : ST_ZERO_DUR;
        res.min_block       = {info_buf[0], info_buf[1]};
        res.max_block       = {info_buf[2], info_buf[3]};
        res.min_frame       = {info_buf[4], info_buf[5], info_buf[6]};
        res.max_frame       = {info_buf[7], info_buf[8], info_buf[9]};
        res.sample_rate     = rate[19:0];
        res.channels        = {1'b0, info_buf[12][3:1]} + 4'd1;
        res.bits_per_sample = {1'b0, info_buf[12][0], info_buf[13][7:4]} + 6'd1;
        res.total_samples   = samples[35:0];
        res.total_seconds   = secs[35:0];
        res.data_start      = offs;
        res.bitrate         = rbits[34:0];
      end
      ph = SCAN_DONE;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] e,
                                      input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      err_cnt++;
    end
  endfunction

  // Sample everything at the rising edge: results first, then config, then new bytes.
  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t pred;
    bit        got;
    in_fire = rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      clear_parse();
      file_sz = '0;
      hdr_expect_q.delete();
    end else begin
      if (in_valid && in_stall) in_held_cycles++;
      if (out_valid && !out_stall) begin
        if (hdr_expect_q.size() == 0) begin
          $display("%0t: result with none expected, actual status %0d data_start %0h",
                   $time, out_data.status, out_data.data_start);
          err_cnt++;
        end else begin
          exp_r = hdr_expect_q.pop_front();
          result_cnt++;
          if (exp_r.status == ST_BAD_MARK) bad_mark_cnt++;
          if (exp_r.status == ST_ZERO_DUR) zero_dur_cnt++;
          check_field("status", 64'(exp_r.status), 64'(out_data.status));
          check_field("min_block", 64'(exp_r.min_block), 64'(out_data.min_block));
          check_field("max_block", 64'(exp_r.max_block), 64'(out_data.max_block));
          check_field("min_frame", 64'(exp_r.min_frame), 64'(out_data.min_frame));
          check_field("max_frame", 64'(exp_r.max_frame), 64'(out_data.max_frame));
          check_field("sample_rate", 64'(exp_r.sample_rate), 64'(out_data.sample_rate));
          check_field("channels", 64'(exp_r.channels), 64'(out_data.channels));
          check_field("bits_per_sample", 64'(exp_r.bits_per_sample),
                      64'(out_data.bits_per_sample));
          check_field("total_samples", 64'(exp_r.total_samples),
                      64'(out_data.total_samples));
          check_field("total_seconds", 64'(exp_r.total_seconds),
                      64'(out_data.total_seconds));
          check_field("data_start", 64'(exp_r.data_start), 64'(out_data.data_start));
          check_field("bitrate", 64'(exp_r.bitrate), 64'(out_data.bitrate));
        end
      end
      if (cfg_valid && cfg_ready) file_sz = cfg_data;
      if (in_fire) begin
        parse_byte(in_data, got, pred);
        if (got) hdr_expect_q.push_back(pred);
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_fire) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data = byte_q.pop_front();
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // result receiver, with one long hold-off when asked for
  always @(negedge clk) begin
    logic nxt_stall;
    if (long_hold_on && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = ($urandom_range(99) < rx_idle_pct);
    end
    out_stall <= nxt_stall;
  end

  task automatic queue_byte(input logic [7:0] d, input bit f, input bit l);
    in_item_t it;
    it.data_byte = d;
    it.first_byte = f;
    it.last_byte = l;
    byte_q.push_back(it);
  endtask

  // One random file: mostly well formed, some with a damaged mark, cut short, or noise.
  task automatic queue_random_file(output int nbytes);
    logic [7:0]  fb [$];
    logic [7:0]  tmp;
    logic [6:0]  kind;
    logic [23:0] len;
    int          nblk, info_at, base, cut, pick, r, nbody;
    bit          with_last, damaged, cut_off;
    nbytes = 0;
    damaged = 1'b0;
    cut_off = 1'b0;
    pick = $urandom_range(99);
    if (pick < 10) begin
      r = $urandom_range(1, 6);
      for (int i = 0; i < r; i++) begin
        tmp = 8'($urandom_range(255));
        queue_byte(tmp, $urandom_range(19) == 0, $urandom_range(9) == 0);
      end
      nbytes = r;
      return;
    end
    for (int k = 0; k < 4; k++) fb.push_back(mark_seq[k]);
    if (pick < 22) begin
      cut = $urandom_range(3);
      tmp = 8'($urandom_range(1, 255));
      fb[cut] = fb[cut] ^ tmp;
      damaged = 1'b1;
    end else begin
      nblk = $urandom_range(1, 4);
      r = $urandom_range(99);
      info_at = (r < 5) ? -1 : (r < 15) ? int'($urandom_range(nblk - 1)) : 0;
      for (int k = 0; k < nblk; k++) begin
        if (k == info_at) begin
          kind = 7'd0;
          case ($urandom_range(9))
            0: len = 24'($urandom_range(0, 17));
            1: len = 24'($urandom_range(35, 45));
            default: len = 24'd34;
          endcase
        end else begin
          kind = 7'($urandom_range(1, 127));
          len = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 12));
          // a huge body is only entered, the stream ends inside it
          if ($urandom_range(19) == 0) begin
            len = 24'($urandom) | 24'h800000;
            cut_off = 1'b1;
          end
        end
        fb.push_back({k == nblk - 1, kind});
        fb.push_back(len[23:16]);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        base = fb.size();
        nbody = (len > 24'd30) ? 30 : int'(len);
        for (int j = 0; j < nbody; j++) begin
          tmp = 8'($urandom_range(255));
          fb.push_back(tmp);
        end
        if (kind == 7'd0 && len >= 24'd18) begin
          case ($urandom_range(9))
            0: begin  // zero sample rate
              fb[base + 10] = 8'h00;
              fb[base + 11] = 8'h00;
              tmp = fb[base + 12];
              fb[base + 12] = {4'h0, tmp[3:0]};
            end
            1: begin  // too few samples for a whole second
              tmp = fb[base + 13];
              fb[base + 13] = {tmp[7:4], 4'h0};
              fb[base + 14] = 8'h00;
              fb[base + 15] = 8'h00;
              fb[base + 16] = 8'h00;
            end
            2, 3: begin  // 44.1 kHz
              fb[base + 10] = 8'h0A;
              fb[base + 11] = 8'hC4;
              tmp = fb[base + 12];
              fb[base + 12] = {4'h4, tmp[3:0]};
            end
            default: ;
          endcase
        end
        if (cut_off) break;
      end
    end
    if (damaged) begin
      with_last = 1'b0;
    end else if (cut_off) begin
      cut = fb.size() - 1;
      with_last = 1'b1;
    end else if (pick < 34) begin
      cut = $urandom_range(fb.size() - 1);
      with_last = 1'b1;
    end else begin
      cut = fb.size() - 1;
      with_last = 1'($urandom_range(1));
    end
    for (int i = 0; i <= cut; i++) queue_byte(fb[i], i == 0, with_last && i == cut);
    nbytes = cut + 1;
    // a few audio bytes past the metadata, ignored by the parser
    if (!damaged && !with_last) begin
      r = $urandom_range(2);
      for (int i = 0; i < r; i++) begin
        tmp = 8'($urandom_range(255));
        queue_byte(tmp, 1'b0, i == r - 1);
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] fsize, input int tx_pct, input int rx_pct,
                           input stim_mode_t mode, input int nbytes);
    int made, n;
    logic [7:0] d;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= fsize;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    made = 0;
    case (mode)
      MODE_DIRECTED: begin
        // bad mark on the very first byte
        queue_byte(8'hFF, 1'b1, 1'b0);
        // stream ends inside the mark
        queue_byte(MARK_0, 1'b1, 1'b0);
        queue_byte(MARK_1, 1'b0, 1'b1);
        // lone last stream info block of zero length: zero duration
        for (int k = 0; k < 4; k++) queue_byte(mark_seq[k], k == 0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // stream info of 34 bytes, stream ends three bytes into the body
        for (int k = 0; k < 4; k++) queue_byte(mark_seq[k], k == 0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h22, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hA5, 1'b0, 1'b1);
        // ignored, parse already ended
        queue_byte(8'h5A, 1'b0, 1'b0);
      end
      MODE_BURST: begin
        long_hold_on = 1'b1;
        for (int i = 0; i < 30; i++) begin
          if (i % 8 == 7) begin
            queue_random_file(n);
          end else begin
            d = 8'($urandom_range(255));
            if (d == MARK_0) d = d ^ 8'h01;
            queue_byte(d, 1'b1, 1'b0);
          end
        end
      end
      default: begin
        while (made < nbytes) begin
          queue_random_file(n);
          made += n;
        end
      end
    endcase
    // restart on a bad byte: closes whatever file is open so the block ends idle
    queue_byte(8'h00, 1'b1, 1'b1);
    while (byte_q.size() != 0 || in_valid || hdr_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_phase(32'd600,        7,  46, MODE_DIRECTED, 0);
    run_phase(32'hFFFF_FFFF,  7,  46, MODE_RANDOM,   400);
    run_phase(32'd0,          46, 7,  MODE_RANDOM,   400);
    run_phase($urandom,       0,  0,  MODE_RANDOM,   400);
    run_phase(32'd60,         0,  0,  MODE_BURST,    0);
    $display("Checked %0d results from %0d parsed bytes (%0d bad mark, %0d zero duration)",
             result_cnt, live_bytes, bad_mark_cnt, zero_dur_cnt);
    $display("File sizes zero, all ones, small and random; input held off %0d cycles",
             in_held_cycles);
    if (err_cnt == 0 && hdr_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- flac_stream_header_parser_top.f -----
rtl/core/flacp_pkg.sv
rtl/core/flacp_front.sv
rtl/core/flacp_queue.sv
rtl/core/flacp_div.sv
rtl/core/flacp_back.sv
rtl/core/flac_stream_header_parser_top.sv
tb/sv/flac_stream_header_parser_top_tb.sv
